// ===== rtl/dewq_pkg.sv =====
// Package for the deferred event window queue.
// Holds sizes, operation and result codes, payload structs and the
// command/status structs between controller and datapath. No dependencies.
package dewq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [1:0] OP_DEFER = 2'd0;
   localparam logic [1:0] OP_FLUSH = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] KIND_EVENT   = 3'd0;
   localparam logic [2:0] KIND_ACCEPT  = 3'd1;
   localparam logic [2:0] KIND_DROPPED = 3'd2;
   localparam logic [2:0] KIND_FLUSHED = 3'd3;
   localparam logic [2:0] KIND_CLEARED = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [23:0] message_bytes;
      logic [1:0]  message_length;
      logic [47:0] target_time;
      logic [47:0] window_base;
      logic [15:0] block_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [23:0] out_bytes;
      logic [1:0]  out_length;
      logic [15:0] sample_offset;
      logic [5:0]  stale_count;
      logic [5:0]  kept_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  length;
      logic [47:0] due;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic emit;
      logic rewind;
      logic finish;
   } dewq_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic scan_idle;
   } dewq_sts_type;

endpackage

// ===== rtl/dewq_ctrl.sv =====
// Controller FSM for the deferred event window queue.
// Sequences the count and emit passes of a flush. Uses dewq_pkg.
module dewq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             op,
   input  dewq_pkg::dewq_sts_type sts,
   output dewq_pkg::dewq_cmd_type cmd,
   output logic                   busy
);

   typedef enum logic [1:0] {ST_IDLE, ST_COUNT, ST_EMIT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start && op == dewq_pkg::OP_FLUSH) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.read = !sts.scan_end;
            if (sts.scan_idle) begin
               cmd.rewind = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.read = !sts.scan_end;
            if (sts.scan_idle) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/dewq_dp.sv =====
// Datapath for the deferred event window queue: entry memory, scan
// counters, window compare and result register. Uses dewq_pkg.
module dewq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  dewq_pkg::req_type      req,
   input  dewq_pkg::dewq_cmd_type cmd,
   output dewq_pkg::dewq_sts_type sts,
   output logic                   rsp_strobe,
   output dewq_pkg::rsp_type      rsp
);

   dewq_pkg::entry_type entry_mem [dewq_pkg::QUEUE_DEPTH];

   logic [dewq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [dewq_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [dewq_pkg::CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [dewq_pkg::CNT_W-1:0] kept_ff, kept_in;
   logic [dewq_pkg::CNT_W-1:0] stale_ff, stale_in;
   logic [47:0]                win_start_ff, win_start_in;
   logic [48:0]                win_end_ff, win_end_in;
   dewq_pkg::entry_type        rd_data_ff;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   dewq_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       mem_we;
   logic [dewq_pkg::IDX_W-1:0] mem_waddr;
   dewq_pkg::entry_type        mem_wdata;
   logic                       in_win, late;
   logic [15:0]                offset;
   logic                       scan_end;

   assign late   = {1'b0, rd_data_ff.due} >= win_end_ff;
   assign in_win = (rd_data_ff.due >= win_start_ff) && !late;
   assign offset = rd_data_ff.due[15:0] - win_start_ff[15:0];

   assign scan_end = (rd_idx_ff == count_ff);
   assign sts      = '{scan_end: scan_end, scan_idle: scan_end && !rd_vld_ff};

   always_comb begin
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      kept_in      = kept_ff;
      stale_in     = stale_ff;
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      rd_vld_in    = cmd.read;
      rsp_vld_in   = 1'b0;
      rsp_in       = '0;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[dewq_pkg::IDX_W-1:0];
      mem_wdata.bytes  = req.message_bytes;
      mem_wdata.length = req.message_length;
      mem_wdata.due    = req.target_time;

      if (cmd.accept) begin
         unique case (req.operation)
            dewq_pkg::OP_DEFER: begin
               rsp_vld_in  = 1'b1;
               rsp_in.last = 1'b1;
               if (count_ff == dewq_pkg::CNT_W'(dewq_pkg::QUEUE_DEPTH)) begin
                  rsp_in.result_kind = dewq_pkg::KIND_DROPPED;
                  rsp_in.kept_count  = 6'(count_ff);
               end else begin
                  mem_we             = 1'b1;
                  count_in           = count_ff + 1'b1;
                  rsp_in.result_kind = dewq_pkg::KIND_ACCEPT;
                  rsp_in.kept_count  = 6'(count_in);
               end
            end
            dewq_pkg::OP_FLUSH: begin
               win_start_in = req.window_base;
               win_end_in   = {1'b0, req.window_base} + {33'd0, req.block_length};
               rd_idx_in    = '0;
               kept_in      = '0;
            end
            dewq_pkg::OP_CLEAR: begin
               count_in           = '0;
               rsp_vld_in         = 1'b1;
               rsp_in.result_kind = dewq_pkg::KIND_CLEARED;
               rsp_in.last        = 1'b1;
            end
            default: begin
               rsp_vld_in = 1'b0;
            end
         endcase
      end

      if (cmd.read) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      // first pass counts survivors, second pass emits and compacts
      if (rd_vld_ff) begin
         if (!cmd.emit) begin
            if (late) begin
               kept_in = kept_ff + 1'b1;
            end
         end else if (in_win) begin
            rsp_vld_in           = 1'b1;
            rsp_in.result_kind   = dewq_pkg::KIND_EVENT;
            rsp_in.out_bytes     = rd_data_ff.bytes;
            rsp_in.out_length    = rd_data_ff.length;
            rsp_in.sample_offset = offset;
            rsp_in.kept_count    = 6'(kept_ff);
         end else if (late) begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff[dewq_pkg::IDX_W-1:0];
            mem_wdata = rd_data_ff;
            wr_idx_in = wr_idx_ff + 1'b1;
         end else begin
            stale_in = stale_ff + 1'b1;
         end
      end

      if (cmd.rewind) begin
         rd_idx_in = '0;
         wr_idx_in = '0;
         stale_in  = '0;
      end

      if (cmd.finish) begin
         count_in           = wr_idx_ff;
         rsp_vld_in         = 1'b1;
         rsp_in.result_kind = dewq_pkg::KIND_FLUSHED;
         rsp_in.stale_count = 6'(stale_ff);
         rsp_in.kept_count  = 6'(wr_idx_ff);
         rsp_in.last        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_data_ff <= entry_mem[rd_idx_ff[dewq_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rd_idx_ff    <= rd_idx_in;
      wr_idx_ff    <= wr_idx_in;
      kept_ff      <= kept_in;
      stale_ff     <= stale_in;
      win_start_ff <= win_start_in;
      win_end_ff   <= win_end_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== rtl/deferred_event_window_queue_unit.sv =====
// Deferred event window queue, top level. Defer and clear strobe their result
// in the cycle after the request with busy staying low, so one may follow every cycle.
// Flush of the stored entries: a count pass and then an emit pass over the single read
// port, busy high throughout; events at most one per cycle; the flush-finished result
// strobes after the emit pass ends.
// Synchronous reset empties the store at once; results cannot be stalled.
module deferred_event_window_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dewq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dewq_pkg::rsp_type rsp_data
);

   dewq_pkg::dewq_cmd_type cmd;
   dewq_pkg::dewq_sts_type sts;

   dewq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_data.operation),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   dewq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// ===== tb/sv/tb_deferred_event_window_queue_unit.sv =====
// Self-checking testbench for deferred_event_window_queue_unit: directed and random
// defer, flush, clear and unused requests, checked against an in-bench shadow of the store.
// Depends on dewq_pkg and the deferred_event_window_queue_unit RTL.
module tb_deferred_event_window_queue_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_GAP = 30;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   dewq_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   dewq_pkg::rsp_type rsp_data;

   dewq_pkg::entry_type shadow_entries [dewq_pkg::QUEUE_DEPTH];
   int                  shadow_count = 0;
   dewq_pkg::rsp_type   pending_answers[$];
   int                  mismatch_count = 0;
   int                  sender_idle_pct = 0;
   int                  stall_cycles = 0;
   logic [47:0]         play_head = '0;

   deferred_event_window_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic dewq_pkg::req_type random_fields();
      dewq_pkg::req_type r;
      r.operation      = 2'($urandom_range(0, 3));
      r.message_bytes  = 24'($urandom);
      r.message_length = 2'($urandom_range(0, 3));
      r.target_time    = rand48();
      r.window_base    = rand48();
      r.block_length   = 16'($urandom);
      return r;
   endfunction

   function automatic dewq_pkg::req_type defer_request(logic [23:0] bytes,
                                                       logic [1:0] length,
                                                       logic [47:0] due);
      dewq_pkg::req_type r;
      r = '0;
      r.operation      = dewq_pkg::OP_DEFER;
      r.message_bytes  = bytes;
      r.message_length = length;
      r.target_time    = due;
      return r;
   endfunction

   function automatic dewq_pkg::req_type flush_request(logic [47:0] first, logic [15:0] size);
      dewq_pkg::req_type r;
      r = '0;
      r.operation    = dewq_pkg::OP_FLUSH;
      r.window_base  = first;
      r.block_length = size;
      return r;
   endfunction

   function automatic dewq_pkg::req_type plain_request(logic [1:0] op);
      dewq_pkg::req_type r;
      r = '0;
      r.operation = op;
      return r;
   endfunction

   // Shadow of the store: queues every answer the request should produce.
   task automatic model_window_queue(input dewq_pkg::req_type r);
      dewq_pkg::rsp_type   answer;
      dewq_pkg::rsp_type   emit_answer;
      dewq_pkg::rsp_type   emitted[$];
      dewq_pkg::entry_type slot;
      logic [48:0]         window_end;
      int                  kept;
      int                  stale;
      answer      = '0;
      answer.last = 1'b1;
      case (r.operation)
         dewq_pkg::OP_DEFER: begin
            if (shadow_count >= dewq_pkg::QUEUE_DEPTH) begin
               answer.result_kind = dewq_pkg::KIND_DROPPED;
            end else begin
               shadow_entries[shadow_count] = '{bytes: r.message_bytes,
                                                length: r.message_length,
                                                due: r.target_time};
               shadow_count++;
               answer.result_kind = dewq_pkg::KIND_ACCEPT;
            end
            answer.kept_count = 6'(shadow_count);
            pending_answers.push_back(answer);
         end
         dewq_pkg::OP_FLUSH: begin
            window_end = {1'b0, r.window_base} + 49'(r.block_length);
            kept  = 0;
            stale = 0;
            for (int i = 0; i < shadow_count; i++) begin
               slot = shadow_entries[i];
               if (slot.due >= r.window_base && {1'b0, slot.due} < window_end) begin
                  emit_answer               = '0;
                  emit_answer.result_kind   = dewq_pkg::KIND_EVENT;
                  emit_answer.out_bytes     = slot.bytes;
                  emit_answer.out_length    = slot.length;
                  emit_answer.sample_offset = 16'(slot.due - r.window_base);
                  emitted.push_back(emit_answer);
               end else if ({1'b0, slot.due} >= window_end) begin
                  shadow_entries[kept] = slot;
                  kept++;
               end else begin
                  stale++;
               end
            end
            shadow_count = kept;
            foreach (emitted[k]) begin
               emitted[k].kept_count = 6'(kept);
               pending_answers.push_back(emitted[k]);
            end
            answer.result_kind = dewq_pkg::KIND_FLUSHED;
            answer.stale_count = 6'(stale);
            answer.kept_count  = 6'(kept);
            pending_answers.push_back(answer);
         end
         dewq_pkg::OP_CLEAR: begin
            shadow_count       = 0;
            answer.result_kind = dewq_pkg::KIND_CLEARED;
            pending_answers.push_back(answer);
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_request(input dewq_pkg::req_type r);
      int gap;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      model_window_queue(r);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic compare_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : answer_check
      dewq_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("result_kind: expected none, got %0d", rsp_data.result_kind);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            compare_field("result_kind", want.result_kind, rsp_data.result_kind);
            compare_field("out_bytes", want.out_bytes, rsp_data.out_bytes);
            compare_field("out_length", want.out_length, rsp_data.out_length);
            compare_field("sample_offset", want.sample_offset, rsp_data.sample_offset);
            compare_field("stale_count", want.stale_count, rsp_data.stale_count);
            compare_field("kept_count", want.kept_count, rsp_data.kept_count);
            compare_field("last", want.last, rsp_data.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_defer_fields();
      send_request(defer_request(24'h000000, 2'd0, 48'd0));
      send_request(defer_request(24'hFFFFFF, 2'd3, TIME_MAX));
      send_request(defer_request(24'hA5A5A5, 2'd1, 48'd100));
      send_request(defer_request(24'h5A5A5A, 2'd2, 48'd65534));
   endtask

   task automatic test_flush_windows();
      // empty window, then a full-width one, then one running past the top of time
      send_request(flush_request(48'd0, 16'd0));
      send_request(flush_request(48'd1, 16'hFFFF));
      send_request(defer_request(24'h123456, 2'd3, 48'hFFFF_FFFF_FF00));
      send_request(flush_request(48'hFFFF_FFFF_FF80, 16'hFFFF));
      // one stale, one emitted, one kept
      send_request(defer_request(24'h0F0F0F, 2'd1, 48'd500));
      send_request(defer_request(24'hF0F0F0, 2'd2, 48'd520));
      send_request(defer_request(24'h3C3C3C, 2'd3, 48'd700));
      send_request(flush_request(48'd510, 16'd100));
   endtask

   task automatic test_clear_and_unused();
      dewq_pkg::req_type r;
      r = '1;
      send_request(r);
      send_request(plain_request(dewq_pkg::OP_CLEAR));
      send_request(flush_request(48'd0, 16'hFFFF));
      send_request(plain_request(dewq_pkg::OP_CLEAR));
      send_request(plain_request(OP_UNUSED));
   endtask

   task automatic test_store_full();
      dewq_pkg::req_type r;
      send_request(plain_request(dewq_pkg::OP_CLEAR));
      repeat (dewq_pkg::QUEUE_DEPTH + 2) begin
         r = random_fields();
         r.operation   = dewq_pkg::OP_DEFER;
         r.target_time = play_head + 48'($urandom_range(0, 2000));
         send_request(r);
      end
      r = random_fields();
      r.operation    = dewq_pkg::OP_FLUSH;
      r.window_base  = play_head;
      r.block_length = 16'hFFFF;
      send_request(r);
      play_head = play_head + 48'hFFFF;
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct);
      dewq_pkg::req_type r;
      int                issued;
      int                roll;
      int                delta;
      sender_idle_pct = idle_pct;
      issued = 0;
      while (issued < count) begin
         roll = $urandom_range(0, 99);
         r    = random_fields();
         if (roll < 4) begin
            if ($urandom_range(0, 1) == 0) play_head = rand48();
            else play_head = TIME_MAX - 48'($urandom_range(0, 4000));
         end else begin
            if (roll < 52) begin
               delta = int'($urandom_range(0, 2600)) - 300;
               r.operation      = dewq_pkg::OP_DEFER;
               r.target_time    = play_head + 48'(delta);
               r.message_length = ($urandom_range(0, 9) == 0) ? 2'd0
                                                               : 2'($urandom_range(1, 3));
            end else if (roll < 80) begin
               r.operation   = dewq_pkg::OP_FLUSH;
               r.window_base = play_head;
               case ($urandom_range(0, 11))
                  0: r.block_length = 16'd0;
                  1: r.block_length = 16'($urandom);
                  default: r.block_length = 16'($urandom_range(16, 1200));
               endcase
               play_head = play_head + 48'(r.block_length);
            end else if (roll < 85) begin
               r.operation = dewq_pkg::OP_CLEAR;
            end else if (roll < 89) begin
               r.operation = OP_UNUSED;
            end
            send_request(r);
            if (r.operation != OP_UNUSED) issued++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_defer_fields();
      test_flush_windows();
      test_clear_and_unused();
      test_store_full();
      test_random_traffic(82, 0);
      test_random_traffic(82, 70);
      test_random_traffic(82, 18);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
